>>> sv/utf8d_pkg.sv
// shared types and constants for the utf8 stream decoder
package utf8d_pkg;

  localparam int ByteW     = 8;
  localparam int CpW       = 21;
  localparam int OutDataW  = 24;
  localparam int CountW    = 3;
  localparam int MaxResults = 4;

  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;

  // decoder state carried between bytes
  typedef struct packed {
    logic [1:0]     rem;
    logic [1:0]     taken;
    logic [CpW-1:0] partial;
  } dec_state_t;

  // results caused by one byte: count-1 replacements, then last_cp
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [CpW-1:0]    last_cp;
  } run_t;

endpackage

>>> sv/utf8d_decode.sv
// per-byte decode logic: next state and the run of results for one byte
module utf8d_decode (
  input  logic [utf8d_pkg::ByteW-1:0] in_byte,
  input  utf8d_pkg::dec_state_t       state,
  output utf8d_pkg::dec_state_t       state_next,
  output utf8d_pkg::run_t             run
);

  logic                        pending;
  logic                        is_cont;
  logic [utf8d_pkg::CpW-1:0]   shifted;
  logic [utf8d_pkg::CountW-1:0] brk_count;
  logic [utf8d_pkg::CountW-1:0] fresh_count;
  logic [utf8d_pkg::CpW-1:0]   fresh_cp;
  utf8d_pkg::dec_state_t       fresh_state;

  assign pending = (state.rem != 2'd0);
  assign is_cont = (in_byte[7:6] == 2'b10);
  assign shifted = {state.partial[utf8d_pkg::CpW-7:0], in_byte[5:0]};

  // replacements for a sequence cut short: lead plus continuations taken
  always_comb begin
    if (!pending) begin
      brk_count = '0;
    end else if (state.taken >= 2'd2) begin
      brk_count = 3'd3;
    end else begin
      brk_count = 3'd1 + {1'b0, state.taken};
    end
  end

  // byte handled with no sequence pending
  always_comb begin
    fresh_state = '0;
    fresh_count = 3'd1;
    fresh_cp    = utf8d_pkg::Replacement;
    if (in_byte[7] == 1'b0) begin
      fresh_cp = {13'd0, in_byte};
    end else if (in_byte[7:5] == 3'b110) begin
      fresh_count         = '0;
      fresh_state.rem     = 2'd1;
      fresh_state.partial = {16'd0, in_byte[4:0]};
    end else if (in_byte[7:4] == 4'b1110) begin
      fresh_count         = '0;
      fresh_state.rem     = 2'd2;
      fresh_state.partial = {17'd0, in_byte[3:0]};
    end else if (in_byte[7:3] == 5'b11110) begin
      fresh_count         = '0;
      fresh_state.rem     = 2'd3;
      fresh_state.partial = {18'd0, in_byte[2:0]};
    end
  end

  // continuation gathering or fresh handling after a possible break
  always_comb begin
    if (pending && is_cont) begin
      if (state.rem == 2'd1) begin
        state_next  = '0;
        run.count   = 3'd1;
        run.last_cp = shifted;
      end else begin
        state_next.rem     = state.rem - 2'd1;
        state_next.taken   = state.taken + 2'd1;
        state_next.partial = shifted;
        run.count          = '0;
        run.last_cp        = utf8d_pkg::Replacement;
      end
    end else begin
      state_next  = fresh_state;
      run.count   = brk_count + fresh_count;
      run.last_cp = (fresh_count != '0) ? fresh_cp : utf8d_pkg::Replacement;
    end
  end

endmodule

>>> sv/utf8d_emit.sv
// output register that plays out the run of results for one byte
module utf8d_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  utf8d_pkg::run_t                run,
  output logic                           free,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [utf8d_pkg::OutDataW-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic                           m_tlast    // last_of_run
);

  logic [utf8d_pkg::CountW-1:0] cnt;
  logic [utf8d_pkg::CountW-1:0] cnt_next;
  logic [utf8d_pkg::CpW-1:0]    last_cp;
  logic                         take;

  assign m_tvalid = (cnt != '0);
  assign take     = m_tvalid && m_tready;
  assign free     = (cnt == '0) || ((cnt == 3'd1) && m_tready);
  assign m_tlast  = (cnt == 3'd1);
  assign m_tdata  = {{(utf8d_pkg::OutDataW - utf8d_pkg::CpW){1'b0}},
                     (cnt > 3'd1) ? utf8d_pkg::Replacement : last_cp};

  // beat countdown, reload when the previous run drains
  always_comb begin
    if (load) begin
      cnt_next = run.count;
    end else if (take) begin
      cnt_next = cnt - 3'd1;
    end else begin
      cnt_next = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // final code point of the run
  always_ff @(posedge clk) begin
    if (load) begin
      last_cp <= run.last_cp;
    end
  end

endmodule

>>> sv/utf8_stream_decoder.sv
// top level of the byte-wise utf8 decoder
// Usage:
//   s_tvalid/s_tready/s_tdata carry one raw text byte per beat.
//   m_tvalid/m_tready/m_tdata/m_tlast carry decoded code points; m_tlast
//   marks the final result caused by one input byte.
//   A byte is registered, decoded combinationally against the sequence
//   state, and its results land in an output register that drives m_tdata.
//   Throughput is one byte per cycle while each byte gives at most one
//   result and m_tready is high. A byte that cuts a sequence short gives
//   up to four results, played out one beat a cycle from the output
//   register while m_tready is high; a following byte with a result
//   waits in the input register until the last beat is taken. Lead bytes
//   that cut no sequence and non-final continuations give no beat. Reset
//   clears the pending sequence and both registers, no beat pending. When
//   the receiver stalls, the output register holds its beat and the input
//   register takes bytes until one gives a result, then s_tready drops.
module utf8_stream_decoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [utf8d_pkg::ByteW-1:0]    s_tdata,   // [7:0] in_byte
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [utf8d_pkg::OutDataW-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic                           m_tlast    // last_of_run
);

  logic                          in_valid;
  logic [utf8d_pkg::ByteW-1:0]   in_byte;
  utf8d_pkg::dec_state_t         state;
  utf8d_pkg::dec_state_t         state_next;
  utf8d_pkg::run_t               run;
  logic                          free;
  logic                          advance;
  logic                          load;

  // byte leaves the input register when its results fit
  assign advance  = in_valid && ((run.count == '0) || free);
  assign load     = advance && (run.count != '0);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  utf8d_decode u_decode (
    .in_byte    (in_byte),
    .state      (state),
    .state_next (state_next),
    .run        (run)
  );

  utf8d_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .run      (run),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // a byte never gives more results than a broken four-byte sequence
  assert property (@(posedge clk) disable iff (rst)
    in_valid |-> (run.count <= 3'(utf8d_pkg::MaxResults)))
    else $error("decoded run longer than allowed");

  // a byte that gives no result leaves a sequence pending
  assert property (@(posedge clk) disable iff (rst)
    (advance && (run.count == '0)) |=> (state.rem != 2'd0))
    else $error("absorbed byte left no pending sequence");

  // every beat before the last of a run is a replacement
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[utf8d_pkg::CpW-1:0] == utf8d_pkg::Replacement))
    else $error("non-final beat is not a replacement");

  // a stalled output keeps the input from running past its run
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && !m_tlast) |-> !load)
    else $error("run reloaded while beats remain");

endmodule

>>> tb/tb_utf8_stream_decoder.sv
// self-checking testbench for the byte-wise utf8 stream decoder
module tb_utf8_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  // kinds of byte groups the random stimulus is built from
  typedef enum int {SymAscii, SymTwo, SymThree, SymFour, SymCut, SymNoise} sym_kind_t;

  // one decoded result as it should appear on the output
  typedef struct {
    logic [utf8d_pkg::CpW-1:0] cp;
    logic                      last;
  } cp_beat_t;

  localparam int HoldCycles = 300;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [utf8d_pkg::ByteW-1:0]    s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [utf8d_pkg::OutDataW-1:0] m_tdata;
  logic                           m_tlast;

  // decoder state mirrored by the predictor
  logic [1:0]                seq_rem = '0;
  logic [1:0]                seq_taken = '0;
  logic [utf8d_pkg::CpW-1:0] seq_partial = '0;

  cp_beat_t expected_cps[$];
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_left = 0;
  int       hold_requests = 0;
  int       hold_served = 0;
  int       errors = 0;
  int       bytes_sent = 0;
  int       beats_checked = 0;
  int       replacements_seen = 0;

  utf8_stream_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // work out the code points one accepted byte gives and queue them
  function automatic void decode_byte(input logic [utf8d_pkg::ByteW-1:0] b);
    logic [utf8d_pkg::CpW-1:0] run[$];
    cp_beat_t                  beat;
    int k;
    if (seq_rem != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        seq_partial = {seq_partial[utf8d_pkg::CpW-7:0], b[5:0]};
        seq_rem = seq_rem - 2'd1;
        if (seq_rem == 2'd0) begin
          beat.cp   = seq_partial;
          beat.last = 1'b1;
          expected_cps.insert(expected_cps.size(), beat);
          seq_taken = '0;
          seq_partial = '0;
        end else begin
          seq_taken = seq_taken + 2'd1;
        end
        return;
      end
      // sequence cut short: replace the lead and each continuation so far
      run.insert(run.size(), utf8d_pkg::Replacement);
      for (k = 0; k < seq_taken && k < 2; k++)
        run.insert(run.size(), utf8d_pkg::Replacement);
      seq_rem = '0;
      seq_taken = '0;
      seq_partial = '0;
    end
    // byte handled with no sequence pending
    if (b[7] == 1'b0) begin
      run.insert(run.size(), utf8d_pkg::CpW'(b));
    end else if (b[7:5] == 3'b110) begin
      seq_partial = utf8d_pkg::CpW'(b[4:0]);
      seq_rem = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      seq_partial = utf8d_pkg::CpW'(b[3:0]);
      seq_rem = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      seq_partial = utf8d_pkg::CpW'(b[2:0]);
      seq_rem = 2'd3;
    end else begin
      run.insert(run.size(), utf8d_pkg::Replacement);
    end
    for (k = 0; k < run.size(); k++) begin
      beat.cp   = run[k];
      beat.last = (k == run.size() - 1);
      expected_cps.insert(expected_cps.size(), beat);
    end
  endfunction

  // offer one byte, with random idle cycles first, until the beat is taken
  task automatic send_byte(input logic [utf8d_pkg::ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    decode_byte(b);
    bytes_sent++;
  endtask

  // one random group of bytes, mostly well-formed sequences
  task automatic send_symbol(output int n);
    sym_kind_t                   kind;
    int                          pick;
    int                          len;
    int                          cont;
    int                          k;
    logic [utf8d_pkg::ByteW-1:0] lead;
    pick = $urandom_range(99);
    kind = pick < 35 ? SymAscii : pick < 50 ? SymTwo : pick < 65 ? SymThree :
           pick < 80 ? SymFour : pick < 90 ? SymCut : SymNoise;
    case (kind)
      SymAscii: begin
        send_byte(8'($urandom_range(127)));
        n = 1;
      end
      SymNoise: begin
        send_byte(8'($urandom_range(255)));
        n = 1;
      end
      default: begin
        len = kind == SymTwo ? 2 : kind == SymThree ? 3 : kind == SymFour ? 4 :
              $urandom_range(4, 2);
        case (len)
          2:       lead = {3'b110, 5'($urandom)};
          3:       lead = {4'b1110, 4'($urandom)};
          default: lead = {5'b11110, 3'($urandom)};
        endcase
        cont = (kind == SymCut) ? $urandom_range(len - 2, 0) : len - 1;
        send_byte(lead);
        for (k = 0; k < cont; k++) send_byte({2'b10, 6'($urandom)});
        n = 1 + cont;
      end
    endcase
  endtask

  // output side: long hold when asked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HoldCycles;
      m_tready    <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare every output beat with the oldest expected code point
  always @(posedge clk) begin : check_beat
    cp_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_cps.size() == 0) begin
        $error("unexpected beat: code_point %h last_of_run %b", m_tdata, m_tlast);
        errors++;
      end else begin
        want = expected_cps.pop_front();
        if (m_tdata !== utf8d_pkg::OutDataW'(want.cp)) begin
          $error("code_point: expected %h, got %h", want.cp, m_tdata);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, m_tlast);
          errors++;
        end
        if (want.cp == utf8d_pkg::Replacement) replacements_seen++;
        beats_checked++;
      end
    end
  end

  task automatic test_ascii();
    send_byte(8'h00);
    send_byte(8'h7F);
  endtask

  task automatic test_sequences();
    // smallest two-byte form, euro sign, largest four-byte pattern
    send_byte(8'hC0); send_byte(8'h80);
    send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAC);
    send_byte(8'hF7); send_byte(8'hBF); send_byte(8'hBF); send_byte(8'hBF);
  endtask

  task automatic test_invalid();
    // stray continuations and leads that start no sequence
    send_byte(8'h80); send_byte(8'hBF);
    send_byte(8'hF8); send_byte(8'hFF);
  endtask

  task automatic test_broken();
    // nul cuts a four-byte sequence after two continuations
    send_byte(8'hF0); send_byte(8'h9F); send_byte(8'h98); send_byte(8'h00);
    // a new lead cuts a three-byte sequence, then completes itself
    send_byte(8'hE2); send_byte(8'h82); send_byte(8'hC3); send_byte(8'hA9);
  endtask

  task automatic test_random(input int n_bytes, input int idle, input int stall);
    int sent;
    int n;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < n_bytes) begin
      send_symbol(n);
      sent += n;
    end
  endtask

  task automatic test_backpressure();
    int k;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    for (k = 0; k < 24; k++) send_byte(8'($urandom_range(127)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_ascii();
    test_sequences();
    test_invalid();
    test_broken();
    test_random(30, 0, 0);
    test_random(30, 76, 0);
    test_random(30, 0, 76);
    test_random(30, 37, 37);
    test_backpressure();
    s_tvalid <= 1'b0;
    wait (expected_cps.size() == 0);
    repeat (20) @(posedge clk);
    if (expected_cps.size() != 0) begin
      $error("%0d expected code points never arrived", expected_cps.size());
      errors++;
    end
    $display("sent %0d bytes: ascii, 2/3/4-byte sequences, stray, invalid and cut sequences",
             bytes_sent);
    $display("checked %0d code points (%0d replacements) under four idle mixes and a long hold",
             beats_checked, replacements_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
